/* src/fqs_pkg.sv */
// fqs_pkg: shared types and constants for the fifo queue with statistics
// used by every module of the block; depends on nothing else

package fqs_pkg;

    // default queue depth
    localparam int DEPTH_DEF = 16;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;
    localparam int OSUM_W = 40;
    localparam int WSUM_W = 48;
    localparam int CNT_W  = 32;

    // operation codes
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // input beat
    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] entry_data;
        logic [DATA_W-1:0] now;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [DATA_W-1:0] removed_data;
        logic              removed_valid;
        logic              add_dropped;
        logic [DATA_W-1:0] wait_time;
        logic [OCC_W-1:0]  occupancy;
        logic [OCC_W-1:0]  min_occupancy;
        logic [OCC_W-1:0]  max_occupancy;
        logic [OSUM_W-1:0] occupancy_sum;
        logic [WSUM_W-1:0] wait_sum;
        logic [CNT_W-1:0]  total_added;
        logic [DATA_W-1:0] head_data;
        logic              head_valid;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_fqs_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_out;
    } t_fqs_cmd;

endpackage

/* src/fifo_queue_with_statistics_top.sv */
// Bounded FIFO of 32-bit entry handles with occupancy and wait statistics.
// Each input beat is an add or a remove carrying the current time; each one
// yields exactly one result beat with the removed entry and its wait, the
// occupancy after the operation, min/max occupancy, saturating sums of
// occupancy and wait, the add count and the head entry. An item passes
// three steps, the accepting edge included (latch, execute with the
// registered memory read of the next head entry, result load), and the
// input is taken again only once the result is loaded, so items do not
// overlap; the result load waits while the output register holds a
// stalled result. A result waiting in the output register does not
// block acceptance of the next item. No clearing pass after reset.
// depends on fqs_pkg, fqs_ctrl and fqs_dpath

module fifo_queue_with_statistics_top #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fqs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fqs_pkg::t_out_item o_out_data
);

    fqs_pkg::t_fqs_cmd cmd;

    // sequencing
    fqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // queue storage and statistics
    fqs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

/* src/fqs_ctrl.sv */
// fqs_ctrl: sequencing state machine and output valid flag
// depends on fqs_pkg

module fqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fqs_pkg::t_fqs_cmd o_cmd
);

    fqs_pkg::t_fqs_state r_state, n_state;
    logic                r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            fqs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = fqs_pkg::ST_EXEC;
                end
            end
            fqs_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = fqs_pkg::ST_EMIT;
            end
            fqs_pkg::ST_EMIT: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = fqs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != fqs_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/fqs_dpath.sv */
// fqs_dpath: entry memories, pointers, head register, statistics and result register
// depends on fqs_pkg; driven by commands from fqs_ctrl

module fqs_dpath #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fqs_pkg::t_fqs_cmd  i_cmd,
    input  fqs_pkg::t_in_item  i_in_data,
    output fqs_pkg::t_out_item o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = fqs_pkg::DATA_W;
    localparam int OW = fqs_pkg::OSUM_W;
    localparam int WW = fqs_pkg::WSUM_W;
    localparam int NW = fqs_pkg::CNT_W;

    // entry memories
    logic [DW-1:0] mem_data [DEPTH];
    logic [DW-1:0] mem_time [DEPTH];

    // latched operation
    logic          r_func;
    logic [DW-1:0] r_entry;
    logic [DW-1:0] r_now;

    // queue control and statistics
    logic [AW-1:0] r_rp, r_wp;
    logic [CW-1:0] r_fill, r_min, r_max;
    logic [OW-1:0] r_occ_sum;
    logic [WW-1:0] r_wait_sum;
    logic [NW-1:0] r_added;
    logic          r_head_load;

    // head entry and memory read data
    logic [DW-1:0] r_head_data, r_head_time;
    logic [DW-1:0] r_rd_data, r_rd_time;

    // per-operation result fields
    logic [DW-1:0] r_rm_data, r_wait;
    logic          r_rm_valid, r_dropped;

    fqs_pkg::t_out_item r_out;

    logic          full, empty, do_add, do_rm;
    logic [AW-1:0] rp_nxt, wp_nxt;
    logic [CW-1:0] fill_inc, fill_dec;
    logic [DW-1:0] wait_w, n_head_data;
    logic [WW:0]   wsum;
    logic [OW:0]   osum;
    logic [NW:0]   asum;

    // operation decode and arithmetic
    assign full     = (r_fill == CW'(DEPTH));
    assign empty    = (r_fill == '0);
    assign do_add   = (r_func == fqs_pkg::FUNC_ADD) && !full;
    assign do_rm    = (r_func == fqs_pkg::FUNC_REMOVE) && !empty;
    assign rp_nxt   = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign wp_nxt   = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign fill_inc = r_fill + 1'b1;
    assign fill_dec = r_fill - 1'b1;
    assign wait_w   = r_now - r_head_time;
    assign wsum     = {1'b0, r_wait_sum} + (WW+1)'(wait_w);
    assign osum     = {1'b0, r_occ_sum} + (OW+1)'(fill_dec);
    assign asum     = {1'b0, r_added} + (NW+1)'(1);
    assign n_head_data = r_head_load ? r_rd_data : r_head_data;

    // pointers, fill count and saturating statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_min       <= CW'(DEPTH);
            r_max       <= '0;
            r_occ_sum   <= '0;
            r_wait_sum  <= '0;
            r_added     <= '0;
            r_head_load <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head_load <= 1'b0;
            if (do_add) begin
                r_wp    <= wp_nxt;
                r_fill  <= fill_inc;
                r_added <= asum[NW] ? '1 : asum[NW-1:0];
                if (fill_inc > r_max) begin
                    r_max <= fill_inc;
                end
            end
            if (do_rm) begin
                r_rp        <= rp_nxt;
                r_fill      <= fill_dec;
                r_wait_sum  <= wsum[WW] ? '1 : wsum[WW-1:0];
                r_occ_sum   <= osum[OW] ? '1 : osum[OW-1:0];
                r_head_load <= (fill_dec != '0);
                if (fill_dec < r_min) begin
                    r_min <= fill_dec;
                end
            end
        end
    end

    // operation latch, memories, head and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func  <= i_in_data.func;
            r_entry <= i_in_data.entry_data;
            r_now   <= i_in_data.now;
        end
        if (i_cmd.exec) begin
            if (do_add) begin
                mem_data[r_wp] <= r_entry;
                mem_time[r_wp] <= r_now;
            end
            // next head entry, used only after a remove
            r_rd_data  <= mem_data[rp_nxt];
            r_rd_time  <= mem_time[rp_nxt];
            r_rm_data  <= do_rm ? r_head_data : '0;
            r_rm_valid <= do_rm;
            r_dropped  <= (r_func == fqs_pkg::FUNC_ADD) && full;
            r_wait     <= do_rm ? wait_w : '0;
            if (do_add && empty) begin
                r_head_data <= r_entry;
                r_head_time <= r_now;
            end
        end
        if (i_cmd.load_out) begin
            if (r_head_load) begin
                r_head_data <= r_rd_data;
                r_head_time <= r_rd_time;
            end
            r_out.removed_data  <= r_rm_data;
            r_out.removed_valid <= r_rm_valid;
            r_out.add_dropped   <= r_dropped;
            r_out.wait_time     <= r_wait;
            r_out.occupancy     <= fqs_pkg::OCC_W'(r_fill);
            r_out.min_occupancy <= fqs_pkg::OCC_W'(r_min);
            r_out.max_occupancy <= fqs_pkg::OCC_W'(r_max);
            r_out.occupancy_sum <= r_occ_sum;
            r_out.wait_sum      <= r_wait_sum;
            r_out.total_added   <= r_added;
            r_out.head_data     <= empty ? '0 : n_head_data;
            r_out.head_valid    <= !empty;
        end
    end

    assign o_out_data = r_out;

endmodule

/* src/fqs_checker.sv */
// fqs_checker: port-level assertions for the fifo queue with statistics
// depends on fqs_pkg; bound to fifo_queue_with_statistics_top

module fqs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fqs_pkg::t_out_item o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one item at a time: the input stalls after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // a result never both removes and drops
    a_rm_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.removed_valid && o_out_data.add_dropped))
        else $error("remove and drop flagged together");

    // without a removed entry the remove fields are zero
    a_rm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.removed_valid |->
            o_out_data.removed_data == '0 && o_out_data.wait_time == '0)
        else $error("remove fields nonzero without an entry");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fifo_queue_with_statistics_top fqs_checker u_fqs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
